// File: hw/rtl/kmst_pkg.sv
// kmst_pkg: shared types and constants for the keyed message slot table.
// Used by kmst_ctrl, kmst_dpath and keyed_message_slot_table_unit.
package kmst_pkg;

  localparam logic [1:0] REQ_INSERT  = 2'd0;
  localparam logic [1:0] REQ_POP_ANY = 2'd1;
  localparam logic [1:0] REQ_POP_KEY = 2'd2;

  // slots scanned per search cycle
  localparam int CHUNK      = 16;
  localparam int CHUNK_BITS = 4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [8:0]  msg_id;
    logic [31:0] payload;
    logic [63:0] key;
    logic [7:0]  client_index;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic        full_res;
    logic [8:0]  out_msg_id;
    logic [31:0] out_payload;
    logic [63:0] out_key;
    logic [7:0]  out_client;
  } out_item_t;

  // stored slot contents
  typedef struct packed {
    logic [8:0]  msg_id;
    logic [31:0] payload;
    logic [63:0] key;
    logic [7:0]  client;
  } slot_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SEARCH,
    ST_FINISH
  } kmst_state_t;

  typedef struct packed {
    logic req_load;   // capture the request beat
    logic cand_load;  // register the candidate slot vector
    logic advance;    // step to the next slot group
    logic commit;     // act on the search outcome
    logic res_load;   // load the output register
  } kmst_cmd_t;

  typedef struct packed {
    logic hit;        // current group holds a candidate
    logic last;       // current group is the final one
  } kmst_sts_t;

endpackage

// File: hw/rtl/kmst_ctrl.sv
// kmst_ctrl: request sequencer and output valid for the slot table.
// Depends on kmst_pkg; drives kmst_dpath through kmst_cmd_t.
module kmst_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  kmst_pkg::kmst_sts_t sts,
  output kmst_pkg::kmst_cmd_t cmd
);

  kmst_pkg::kmst_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kmst_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    unique case (state_r)
      kmst_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_nxt    = kmst_pkg::ST_MATCH;
        end
      end
      kmst_pkg::ST_MATCH: begin
        cmd.cand_load = 1'b1;
        state_nxt     = kmst_pkg::ST_SEARCH;
      end
      kmst_pkg::ST_SEARCH: begin
        if (sts.hit || sts.last) begin
          cmd.commit = 1'b1;
          state_nxt  = kmst_pkg::ST_FINISH;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      kmst_pkg::ST_FINISH: begin
        // output register is free or drains this cycle
        if (!out_valid_r || !out_stall) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = kmst_pkg::ST_IDLE;
        end
      end
      default: state_nxt = kmst_pkg::ST_IDLE;
    endcase
  end

  assign in_stall  = (state_r != kmst_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: hw/rtl/kmst_dpath.sv
// kmst_dpath: slot valid bits, key compare lanes, slot memory, group search
// and output register. Depends on kmst_pkg; commanded by kmst_ctrl.
module kmst_dpath #(
  parameter int SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kmst_pkg::in_item_t  in_data,
  input  kmst_pkg::kmst_cmd_t cmd,
  output kmst_pkg::kmst_sts_t sts,
  output kmst_pkg::out_item_t out_data
);

  localparam int NCHUNK = (SLOTS + kmst_pkg::CHUNK - 1) / kmst_pkg::CHUNK;
  localparam int PADW   = NCHUNK * kmst_pkg::CHUNK;
  localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int IW     = CW + kmst_pkg::CHUNK_BITS;
  localparam int SW     = $clog2(SLOTS);

  kmst_pkg::in_item_t          req_r;
  logic [SLOTS-1:0]            valid_r;
  logic [63:0]                 key_r [SLOTS];
  kmst_pkg::slot_entry_t       mem [SLOTS];
  kmst_pkg::slot_entry_t       rd_r;
  logic [PADW-1:0]             cand_r, cand_nxt;
  logic [CW-1:0]               chunk_r;
  logic                        hit_r;
  kmst_pkg::out_item_t         out_r;

  logic [kmst_pkg::CHUNK-1:0]      grp;
  logic [kmst_pkg::CHUNK_BITS-1:0] pos;
  logic [IW-1:0]                   sidx;
  logic [SW-1:0]                   slot;
  logic                            is_pop;
  kmst_pkg::slot_entry_t           wr_entry;

  assign is_pop = (req_r.req_type == kmst_pkg::REQ_POP_ANY) ||
                  (req_r.req_type == kmst_pkg::REQ_POP_KEY);

  // candidate vector: free slots for insert, occupied (and matching) for pops
  always_comb begin
    cand_nxt = '0;
    for (int i = 0; i < SLOTS; i++) begin
      unique case (req_r.req_type)
        kmst_pkg::REQ_INSERT:  cand_nxt[i] = !valid_r[i];
        kmst_pkg::REQ_POP_ANY: cand_nxt[i] = valid_r[i];
        kmst_pkg::REQ_POP_KEY: cand_nxt[i] = valid_r[i] && (key_r[i] == req_r.key);
        default:               cand_nxt[i] = 1'b0;
      endcase
    end
  end

  // lowest set bit of the current group
  always_comb begin
    grp = cand_r[chunk_r * kmst_pkg::CHUNK +: kmst_pkg::CHUNK];
    pos = '0;
    for (int j = kmst_pkg::CHUNK - 1; j >= 0; j--) begin
      if (grp[j]) pos = j[kmst_pkg::CHUNK_BITS-1:0];
    end
  end

  assign sidx     = {chunk_r, pos};
  assign slot     = sidx[SW-1:0];
  assign sts.hit  = |grp;
  assign sts.last = (chunk_r == CW'(NCHUNK - 1));

  assign wr_entry.msg_id  = req_r.msg_id;
  assign wr_entry.payload = req_r.payload;
  assign wr_entry.key     = req_r.key;
  assign wr_entry.client  = req_r.client_index;

  always_ff @(posedge clk) begin
    if (cmd.req_load) req_r <= in_data;
    if (cmd.cand_load) cand_r <= cand_nxt;
    if (cmd.commit) hit_r <= sts.hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      chunk_r <= '0;
    end else begin
      if (cmd.cand_load) chunk_r <= '0;
      else if (cmd.advance) chunk_r <= chunk_r + 1'b1;
      if (cmd.commit && sts.hit) begin
        if (req_r.req_type == kmst_pkg::REQ_INSERT) valid_r[slot] <= 1'b1;
        else if (is_pop) valid_r[slot] <= 1'b0;
      end
    end
  end

  // key lanes are compared in parallel, so they live in flops beside the memory
  always_ff @(posedge clk) begin
    if (cmd.commit && sts.hit && req_r.req_type == kmst_pkg::REQ_INSERT) begin
      key_r[slot] <= req_r.key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && sts.hit && req_r.req_type == kmst_pkg::REQ_INSERT) begin
      mem[slot] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) rd_r <= mem[slot];
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_r.found    <= hit_r && is_pop;
      out_r.full_res <= !hit_r && (req_r.req_type == kmst_pkg::REQ_INSERT);
      if (hit_r && is_pop) begin
        out_r.out_msg_id  <= rd_r.msg_id;
        out_r.out_payload <= rd_r.payload;
        out_r.out_key     <= rd_r.key;
        out_r.out_client  <= rd_r.client;
      end else begin
        out_r.out_msg_id  <= '0;
        out_r.out_payload <= '0;
        out_r.out_key     <= '0;
        out_r.out_client  <= '0;
      end
    end
  end

  assign out_data = out_r;

endmodule

// File: hw/rtl/keyed_message_slot_table_unit.sv
// keyed_message_slot_table_unit: top level of the keyed message slot table.
// Depends on kmst_pkg, kmst_ctrl and kmst_dpath.
//
// A table of SLOTS message slots. Insert stores a beat into the lowest free
// slot (full_res and a dropped message when none is free); pop-any and
// pop-by-key take and free the lowest occupied or lowest key-matching slot.
// Every request beat yields one result beat. One request is in flight at a
// time: after acceptance it passes through a match state that registers the
// candidate vector, a search state that walks the 16-slot groups in order
// (one to ceil(SLOTS/16) of them) until it hits or runs out, and a finish
// state that loads the result once the output register is free or draining;
// only then is the next beat accepted.
// A finished result sits in the output register, so the next request is
// taken while it waits.
// Slot valid bits clear at reset; no clearing pass is needed.
module keyed_message_slot_table_unit #(
  parameter int SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  kmst_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output kmst_pkg::out_item_t out_data
);

  kmst_pkg::kmst_cmd_t cmd;
  kmst_pkg::kmst_sts_t sts;

  kmst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  kmst_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// File: sim/keyed_message_slot_table_unit_tb.sv
// keyed_message_slot_table_unit_tb: self-checking bench for the keyed message slot table.
// Drives insert / pop-any / pop-by-key beats with random idling and checks every result
// against an in-bench slot table model. Depends on kmst_pkg and keyed_message_slot_table_unit.
module keyed_message_slot_table_unit_tb;

  localparam int NUM_SLOTS = 16;
  localparam int HOLD_CYCLES = 80;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  kmst_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  kmst_pkg::out_item_t out_data;

  keyed_message_slot_table_unit #(.SLOTS(NUM_SLOTS)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model of the slot table
  logic                  occ [NUM_SLOTS];
  kmst_pkg::slot_entry_t slot_mem [NUM_SLOTS];

  kmst_pkg::in_item_t  request_q [$];
  kmst_pkg::out_item_t response_q [$];
  int        errors = 0;
  bit        gaps_on = 1'b1;
  int        hold_reqs = 0;
  int        hold_seen = 0;
  int        send_gap = 0;
  int        stall_left = 0;
  logic [63:0] key_pool [6];

  function automatic kmst_pkg::out_item_t predict_response(kmst_pkg::in_item_t r);
    kmst_pkg::out_item_t res;
    int idx;
    res = '0;
    idx = -1;
    case (r.req_type)
      kmst_pkg::REQ_INSERT: begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (!occ[i] && idx < 0) idx = i;
        if (idx < 0) begin
          res.full_res = 1'b1;
        end else begin
          occ[idx] = 1'b1;
          slot_mem[idx] = '{msg_id: r.msg_id, payload: r.payload, key: r.key,
                            client: r.client_index};
        end
      end
      kmst_pkg::REQ_POP_ANY, kmst_pkg::REQ_POP_KEY: begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (occ[i] && idx < 0 &&
              (r.req_type == kmst_pkg::REQ_POP_ANY || slot_mem[i].key == r.key))
            idx = i;
        if (idx >= 0) begin
          res.found = 1'b1;
          res.out_msg_id = slot_mem[idx].msg_id;
          res.out_payload = slot_mem[idx].payload;
          res.out_key = slot_mem[idx].key;
          res.out_client = slot_mem[idx].client;
          occ[idx] = 1'b0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic kmst_pkg::in_item_t mk_req(logic [1:0] rt, logic [8:0] id,
                                                logic [31:0] pay, logic [63:0] k,
                                                logic [7:0] cli);
    kmst_pkg::in_item_t r;
    r.req_type = rt;
    r.msg_id = id;
    r.payload = pay;
    r.key = k;
    r.client_index = cli;
    return r;
  endfunction

  function automatic kmst_pkg::in_item_t rand_req(int ins_pct);
    logic [1:0]  rt;
    logic [63:0] k;
    if ($urandom_range(0, 99) < ins_pct) rt = kmst_pkg::REQ_INSERT;
    else if ($urandom_range(0, 1) == 0) rt = kmst_pkg::REQ_POP_ANY;
    else rt = kmst_pkg::REQ_POP_KEY;
    // mostly pooled keys so keyed pops find matches
    if ($urandom_range(0, 99) < 80) k = key_pool[$urandom_range(0, 5)];
    else k = {$urandom, $urandom};
    return mk_req(rt, 9'($urandom_range(0, 511)), $urandom, k, 8'($urandom_range(0, 255)));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall)
        response_q.push_back(predict_response(in_data));
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          in_data <= request_q.pop_front();
          in_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    kmst_pkg::out_item_t exp_res;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (response_q.size() == 0) begin
          $error("unexpected result beat %h", out_data);
          errors++;
        end else begin
          exp_res = response_q.pop_front();
          if (out_data.found !== exp_res.found) begin
            $error("found: expected %0h, got %0h", exp_res.found, out_data.found);
            errors++;
          end
          if (out_data.full_res !== exp_res.full_res) begin
            $error("full_res: expected %0h, got %0h", exp_res.full_res, out_data.full_res);
            errors++;
          end
          if (out_data.out_msg_id !== exp_res.out_msg_id) begin
            $error("out_msg_id: expected %0h, got %0h", exp_res.out_msg_id,
                   out_data.out_msg_id);
            errors++;
          end
          if (out_data.out_payload !== exp_res.out_payload) begin
            $error("out_payload: expected %0h, got %0h", exp_res.out_payload,
                   out_data.out_payload);
            errors++;
          end
          if (out_data.out_key !== exp_res.out_key) begin
            $error("out_key: expected %0h, got %0h", exp_res.out_key, out_data.out_key);
            errors++;
          end
          if (out_data.out_client !== exp_res.out_client) begin
            $error("out_client: expected %0h, got %0h", exp_res.out_client,
                   out_data.out_client);
            errors++;
          end
        end
      end
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("keyed_message_slot_table_unit_tb failed");
    $finish;
  end

  initial begin
    int ins_pct [7];
    for (int i = 0; i < NUM_SLOTS; i++) begin
      occ[i] = 1'b0;
      slot_mem[i] = '0;
    end
    ins_pct = '{70, 30, 55, 85, 15, 50, 60};
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 6; i++) key_pool[i] = {$urandom, $urandom};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty pops, extremes, fill to full, overflow, keyed hits and misses
    request_q.push_back(mk_req(kmst_pkg::REQ_POP_ANY, '1, '1, '1, '1));
    request_q.push_back(mk_req(kmst_pkg::REQ_POP_KEY, '0, '0, '1, '0));
    request_q.push_back(mk_req(kmst_pkg::REQ_INSERT, 9'h1ff, 32'hffff_ffff, '1, 8'hff));
    request_q.push_back(mk_req(kmst_pkg::REQ_INSERT, '0, '0, '0, '0));
    for (int i = 2; i < NUM_SLOTS; i++)
      request_q.push_back(mk_req(kmst_pkg::REQ_INSERT, 9'(i * 37), 32'h1000_0000 + i,
                                 (i % 3 == 0) ? '1 : 64'h0123_4567_89ab_0000 + i, 8'(i)));
    request_q.push_back(mk_req(kmst_pkg::REQ_INSERT, 9'h0aa, 32'hdead_beef, 64'h55, 8'h11));
    request_q.push_back(mk_req(kmst_pkg::REQ_POP_KEY, '0, '0, '1, '0));
    request_q.push_back(mk_req(kmst_pkg::REQ_POP_KEY, '0, '0, 64'hdead_0000_beef_0000, '0));
    request_q.push_back(mk_req(kmst_pkg::REQ_POP_ANY, '0, '0, '0, '0));
    request_q.push_back(mk_req(kmst_pkg::REQ_INSERT, 9'h155, 32'h5a5a_a5a5, '0, 8'h80));
    request_q.push_back(mk_req(kmst_pkg::REQ_POP_KEY, '0, '0, '0, '0));

    for (int ph = 0; ph < 7; ph++) begin
      // pause the sender until every result is back
      do @(negedge clk);
      while (request_q.size() != 0 || in_valid || response_q.size() != 0);
      gaps_on = (ph != 2 && ph != 4);
      for (int n = 0; n < 100; n++) request_q.push_back(rand_req(ins_pct[ph]));
      if (ph == 4) begin
        repeat (3) @(negedge clk);
        hold_reqs++;
      end
    end

    do @(negedge clk);
    while (request_q.size() != 0 || in_valid || response_q.size() != 0);
    repeat (16) @(negedge clk);
    if (errors == 0 && response_q.size() == 0) begin
      $display("keyed_message_slot_table_unit_tb passed");
    end else begin
      $display("keyed_message_slot_table_unit_tb failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/kmst_pkg.sv
hw/rtl/kmst_ctrl.sv
hw/rtl/kmst_dpath.sv
hw/rtl/keyed_message_slot_table_unit.sv
sim/keyed_message_slot_table_unit_tb.sv
